// ===== design/pia_pkg.sv =====
// Shared types and constants for the page id allocator.
// No dependencies; every other design file imports this package.
`default_nettype none

package pia_pkg;

  localparam int unsigned PAGE_W         = 10;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned LIMIT_W        = 11;
  localparam int unsigned DEF_POOL_PAGES = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } pia_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_PAGES = 2'd1,
    ST_NEVER_ALLOC  = 2'd2,
    ST_NOT_IN_USE   = 2'd3
  } pia_status_e;

endpackage

`default_nettype wire

// ===== design/pia_if.sv =====
// Request and response channel interfaces of the page id allocator.
// Depends on pia_pkg for the field widths.
`default_nettype none

interface pia_req_if;
  import pia_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [PAGE_W-1:0] page_in;

  modport source (output valid, output func, output page_in, input ready);
  modport sink   (input valid, input func, input page_in, output ready);
endinterface

interface pia_rsp_if;
  import pia_pkg::*;

  logic                valid;
  logic                ready;
  logic [PAGE_W-1:0]   page_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output page_out, output status, input ready);
  modport sink   (input valid, input page_out, input status, output ready);
endinterface

`default_nettype wire

// ===== design/page_id_allocator.sv =====
// Page id allocator: free list stack with a bump pointer fallback.
// Depends on pia_pkg and the channel interfaces in pia_if.sv.
//
// Each request gives exactly one response, loaded into the response register
// from the input register, and a new request may be accepted in every cycle
// while responses are taken. The accepting edge also registers the read of the
// in-use bit memory at the page of the request; the outcome is decided from the
// stack top registers and counters and loaded into the response register once
// that register is free. A response that is not taken holds the following
// request in the input register until it is. The top of the free stack and the
// entry below it live in registers, so back to back allocations and frees never
// wait on the stack memory. No clearing pass follows reset: an in-use bit is
// only consulted for pages below the bump pointer, which have all been written.
// The page limit may only be changed while no request is in flight.
`default_nettype none

module page_id_allocator #(
  parameter int unsigned POOL_PAGES = pia_pkg::DEF_POOL_PAGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pia_req_if.sink                    req_i,
  pia_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [pia_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import pia_pkg::*;

  localparam int unsigned IdW  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CntW = $clog2(POOL_PAGES + 1);
  localparam int unsigned CmpW = (CntW > LIMIT_W) ? CntW : LIMIT_W;
  localparam logic [CmpW-1:0] PoolCmp = CmpW'(POOL_PAGES);
  localparam logic [CntW-1:0] PoolCnt = CntW'(POOL_PAGES);

  logic [LIMIT_W-1:0]  limit_q;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_func_q;
  logic [PAGE_W-1:0]   s1_page_q;
  logic                s1_used_q;
  logic [CntW-1:0]     mark_q, mark_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdW-1:0]      top_q, top_d;
  logic [IdW-1:0]      second_q;
  logic                rsp_valid_q, rsp_valid_d;
  logic [PAGE_W-1:0]   rsp_page_q;
  logic [STATUS_W-1:0] rsp_status_q;

  logic [IdW-1:0] stack_mem [POOL_PAGES];
  logic           use_mem   [POOL_PAGES];

  logic              advance, accept, is_free, push, pop;
  logic [CmpW-1:0]   page_ext, in_page_ext, lim, mark_ext, res_page;
  logic [IdW-1:0]    use_raddr, use_waddr;
  logic              use_we, use_wdata;
  logic [CntW-1:0]   cnt_m1, cnt_m3;
  pia_status_e       res_status;

  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  assign in_page_ext = CmpW'(req_i.page_in);
  assign use_raddr   = in_page_ext[IdW-1:0];
  assign page_ext    = CmpW'(s1_page_q);
  assign mark_ext    = CmpW'(mark_q);
  assign lim         = (CmpW'(limit_q) > PoolCmp) ? PoolCmp : CmpW'(limit_q);
  assign is_free     = (s1_func_q == FUNC_FREE);
  assign cnt_m1      = cnt_q - CntW'(1);
  assign cnt_m3      = cnt_q - CntW'(3);

  always_comb begin
    res_page   = '0;
    res_status = ST_OK;
    mark_d     = mark_q;
    cnt_d      = cnt_q;
    top_d      = top_q;
    use_we     = 1'b0;
    use_waddr  = page_ext[IdW-1:0];
    use_wdata  = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    if (advance) begin
      if (!is_free) begin
        if (cnt_q != '0) begin
          pop       = 1'b1;
          cnt_d     = cnt_m1;
          top_d     = second_q;
          use_we    = 1'b1;
          use_waddr = top_q;
          use_wdata = 1'b1;
          res_page  = CmpW'(top_q);
        end else if (mark_ext < lim) begin
          mark_d    = mark_q + CntW'(1);
          use_we    = 1'b1;
          use_waddr = mark_q[IdW-1:0];
          use_wdata = 1'b1;
          res_page  = mark_ext;
        end else begin
          res_status = ST_OUT_OF_PAGES;
        end
      end else begin
        if (page_ext >= mark_ext || page_ext >= PoolCmp) begin
          res_status = ST_NEVER_ALLOC;
        end else if (!s1_used_q) begin
          res_status = ST_NOT_IN_USE;
        end else begin
          use_we    = 1'b1;
          use_wdata = 1'b0;
          res_page  = page_ext;
          if (cnt_q != PoolCnt) begin
            push  = 1'b1;
            cnt_d = cnt_q + CntW'(1);
            top_d = page_ext[IdW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (advance) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      s1_valid_q  <= 1'b0;
      mark_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      mark_q      <= mark_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept) begin
      s1_func_q <= req_i.func;
      s1_page_q <= req_i.page_in;
    end
    if (advance) begin
      rsp_page_q   <= res_page[PAGE_W-1:0];
      rsp_status_q <= res_status;
    end
  end

  // The stack memory holds every entry below the top; the entry just below
  // the top is kept in second_q, refilled from memory on a pop.
  always_ff @(posedge clk_i) begin
    if (push && cnt_q != '0) begin
      stack_mem[cnt_m1[IdW-1:0]] <= top_q;
    end
    if (push) begin
      second_q <= top_q;
    end else if (pop) begin
      second_q <= stack_mem[cnt_m3[IdW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    if (accept) begin
      if (use_we && use_waddr == use_raddr) begin
        s1_used_q <= use_wdata;
      end else begin
        s1_used_q <= use_mem[use_raddr];
      end
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.page_out = rsp_page_q;
  assign rsp_o.status   = rsp_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mark_q)
    else $error("More pages on the free stack than were ever handed out.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= PoolCnt)
    else $error("Bump pointer ran past the pool.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_status != ST_OK |=> $stable(cnt_q) && $stable(mark_q))
    else $error("A failed request changed the allocator state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !is_free && cnt_q == '0 && res_status == ST_OK
    |=> mark_q == $past(mark_q) + CntW'(1))
    else $error("A fresh allocation did not advance the bump pointer.");

endmodule

`default_nettype wire

// ===== tb/sv/tb_page_id_allocator.sv =====
// Self-checking testbench for page_id_allocator: directed and random requests
// with random stalls on both channels, checked against an in-bench allocator.
// Depends on pia_pkg, the channel interfaces in pia_if.sv and the RTL.
`default_nettype none

module tb_page_id_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pia_pkg::*;

  localparam int unsigned POOL = DEF_POOL_PAGES;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    pia_status_e       status;
  } grant_t;

  typedef struct packed {
    pia_func_e         func;
    logic [PAGE_W-1:0] page;
    logic              known;
    grant_t            grant;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 24;

  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{FUNC_FREE,  10'd0,    1'b1, '{10'd0, ST_NEVER_ALLOC}},
    '{FUNC_FREE,  10'd1023, 1'b1, '{10'd0, ST_NEVER_ALLOC}},
    '{FUNC_ALLOC, 10'd1023, 1'b1, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd1,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd1,    1'b1, '{10'd0, ST_NOT_IN_USE}},
    '{FUNC_FREE,  10'd3,    1'b1, '{10'd0, ST_NEVER_ALLOC}},
    '{FUNC_FREE,  10'd2,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd1023, 1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd3,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd2,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd1,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd1,    1'b1, '{10'd0, ST_NOT_IN_USE}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_ALLOC, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{FUNC_FREE,  10'd1023, 1'b1, '{10'd0, ST_NEVER_ALLOC}},
    '{FUNC_FREE,  10'd512,  1'b1, '{10'd0, ST_NEVER_ALLOC}}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  pia_req_if req_if ();
  pia_rsp_if rsp_if ();

  page_id_allocator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  logic [LIMIT_W-1:0] limit_reg;
  int unsigned        fresh_mark;
  int unsigned        free_depth;
  logic [PAGE_W-1:0]  free_pages [0:POOL-1];
  bit                 page_busy [0:POOL-1];

  grant_t      expected_grants [$];
  int unsigned errors;
  int unsigned sent_count;
  bit          send_burst;
  bit          drain_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void predict_grant(input pia_func_e f, input logic [PAGE_W-1:0] pg,
                                        output grant_t g);
    int unsigned id;
    int unsigned lim;
    lim = (limit_reg > POOL) ? POOL : limit_reg;
    g = '{page: '0, status: ST_OK};
    if (f == FUNC_ALLOC) begin
      if (free_depth > 0) begin
        free_depth--;
        id = free_pages[free_depth];
      end else if (fresh_mark < lim) begin
        id = fresh_mark;
        fresh_mark++;
      end else begin
        g.status = ST_OUT_OF_PAGES;
        return;
      end
      page_busy[id] = 1'b1;
      g.page = id[PAGE_W-1:0];
    end else if (pg >= fresh_mark) begin
      g.status = ST_NEVER_ALLOC;
    end else if (!page_busy[pg]) begin
      g.status = ST_NOT_IN_USE;
    end else begin
      page_busy[pg] = 1'b0;
      if (free_depth < POOL) begin
        free_pages[free_depth] = pg;
        free_depth++;
      end
      g.page = pg;
    end
  endfunction

  function automatic bit find_page(input bit busy, inout logic [PAGE_W-1:0] pg);
    int unsigned first;
    int unsigned idx;
    if (fresh_mark == 0) return 1'b0;
    first = $urandom_range(0, fresh_mark - 1);
    for (int unsigned k = 0; k < fresh_mark; k++) begin
      idx = (first + k) % fresh_mark;
      if (page_busy[idx] == busy) begin
        pg = idx[PAGE_W-1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void pick_request(input int unsigned alloc_pct, output pia_func_e f,
                                       output logic [PAGE_W-1:0] pg);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    pg = PAGE_W'($urandom);
    f = (roll < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
    if (f == FUNC_FREE) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        void'(find_page(1'b1, pg));
      end else if (roll < 85) begin
        void'(find_page(1'b0, pg));
      end
    end
  endfunction

  task automatic send_request(input pia_func_e f, input logic [PAGE_W-1:0] pg,
                              input bit known, input grant_t typed_grant);
    int unsigned gap;
    grant_t g;
    if (sent_count % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= f;
    req_if.page_in <= pg;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_grant(f, pg, g);
    expected_grants.push_back(known ? typed_grant : g);
    sent_count++;
  endtask

  task automatic wait_all_granted();
    req_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_all_granted();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned alloc_pct);
    pia_func_e f;
    logic [PAGE_W-1:0] pg;
    repeat (count) begin
      pick_request(alloc_pct, f, pg);
      send_request(f, pg, 1'b0, '0);
    end
  endtask

  initial begin : rsp_drain
    int unsigned stall;
    int unsigned seen;
    seen = 0;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (seen % 64 == 0) drain_burst = ($urandom_range(0, 3) == 0);
      stall = drain_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (rsp_if.valid !== 1'b1) @(posedge clk);
      seen++;
    end
  end

  always @(posedge clk) begin : grant_check
    grant_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_grants.size() == 0) begin
        if (errors < 10) begin
          $display("%0t: response with none pending: page %0d status %0d", $realtime,
                   rsp_if.page_out, rsp_if.status);
        end
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (rsp_if.page_out !== want.page || rsp_if.status !== want.status) begin
          if (errors < 10) begin
            $display("%0t: mismatch: expected page %0d status %s, got page %0d status %0d",
                     $realtime, want.page, want.status.name(), rsp_if.page_out,
                     rsp_if.status);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    errors         = 0;
    sent_count     = 0;
    send_burst     = 1'b0;
    drain_burst    = 1'b0;
    fresh_mark     = 0;
    free_depth     = 0;
    limit_reg      = LIMIT_RESET;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = LIMIT_RESET;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_ALLOC;
    req_if.page_in = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < N_DIRECTED; i++) begin
      send_request(directed_rows[i].func, directed_rows[i].page, directed_rows[i].known,
                   directed_rows[i].grant);
    end

    write_limit(LIMIT_W'(1));
    run_random(30, 60);
    write_limit(LIMIT_W'(0));
    run_random(20, 50);
    write_limit(LIMIT_W'(2047));
    run_random(300, 97);
    wait_all_granted();
    while (fresh_mark < POOL) run_random(50, 97);
    run_random(20, 93);
    write_limit(LIMIT_W'(1024));
    run_random(40, 50);
    write_limit(LIMIT_W'($urandom_range(1, 1023)));
    run_random(40, 45);

    wait_all_granted();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/pia_pkg.sv
design/pia_if.sv
design/page_id_allocator.sv
tb/sv/tb_page_id_allocator.sv
